@@ hdl/dsfe_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// Dithered span fill engine package
// Shared constants, types and the dither pattern table.
// ---------------------------------------------------------------------------
package dsfe_pkg;

    localparam int DEF_SCREEN_WIDTH  = 128;
    localparam int DEF_SCREEN_HEIGHT = 64;

    // Byte address of a span byte: 8-bit row times at most 32 bytes plus a
    // 5-bit byte column stays below 8192.
    localparam int SPAN_ADDR_W = 13;
    // One more bit so the store size itself (up to 8192) can be compared.
    localparam int SIZE_W      = SPAN_ADDR_W + 1;

    // Configuration register indexes
    localparam logic [2:0] CFG_WINDOW_LEFT   = 3'd0;
    localparam logic [2:0] CFG_WINDOW_TOP    = 3'd1;
    localparam logic [2:0] CFG_WINDOW_WIDTH  = 3'd2;
    localparam logic [2:0] CFG_WINDOW_HEIGHT = 3'd3;
    localparam logic [2:0] CFG_DITHER_LEVEL  = 3'd4;

    // Reset values of the configuration registers
    localparam logic [6:0] RST_WINDOW_LEFT   = 7'd0;
    localparam logic [5:0] RST_WINDOW_TOP    = 6'd0;
    localparam logic [7:0] RST_WINDOW_WIDTH  = 8'd128;
    localparam logic [6:0] RST_WINDOW_HEIGHT = 7'd64;
    localparam logic [4:0] RST_DITHER_LEVEL  = 5'd8;
    localparam logic [4:0] MAX_DITHER_LEVEL  = 5'd16;

    // Item kinds
    localparam logic FUNC_FILL = 1'b0;
    localparam logic FUNC_READ = 1'b1;

    typedef enum logic [1:0] {
        OP_CLEAR  = 2'd0,
        OP_SET    = 2'd1,
        OP_INVERT = 2'd2,
        OP_NONE   = 2'd3
    } color_op_t;

    // Registered span plan handed from the setup stage to the RMW walker
    typedef struct packed {
        logic                   drawn;
        color_op_t              op;
        logic [7:0]             pat;
        logic [7:0]             mask_start;
        logic [7:0]             mask_end;
        logic [SPAN_ADDR_W-1:0] base;
        logic [4:0]             byte_start;
        logic [4:0]             byte_end;
    } span_plan_t;

    // Four-row dither pattern: rows packed {row3, row2, row1, row0}
    function automatic logic [7:0] dither_row(input logic [4:0] level,
                                              input logic [1:0] r);
        logic [31:0] rows;
        case (level)
            5'd0:    rows = 32'h0000_0000;
            5'd1:    rows = 32'h0000_0088;
            5'd2:    rows = 32'h0022_0088;
            5'd3:    rows = 32'h00aa_0088;
            5'd4:    rows = 32'h00aa_00aa;
            5'd5:    rows = 32'h00aa_44aa;
            5'd6:    rows = 32'h11aa_44aa;
            5'd7:    rows = 32'h55aa_44aa;
            5'd8:    rows = 32'h55aa_55aa;
            5'd9:    rows = 32'h55aa_ddaa;
            5'd10:   rows = 32'h77aa_ddaa;
            5'd11:   rows = 32'hffaa_ddaa;
            5'd12:   rows = 32'hffaa_ffaa;
            5'd13:   rows = 32'hffaa_ffbb;
            5'd14:   rows = 32'hffee_ffbb;
            5'd15:   rows = 32'hffff_ffbb;
            default: rows = 32'hffff_ffff;
        endcase
        return rows[{r, 3'b000} +: 8];
    endfunction

endpackage
`default_nettype wire

@@ hdl/dsfe_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port, one read port, read data registered.
// ---------------------------------------------------------------------------
module dsfe_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

@@ hdl/dsfe_span_plan.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// Span setup stage
// Order, window-check, translate and clip one span; build masks and pattern.
// ---------------------------------------------------------------------------
module dsfe_span_plan #(
    parameter int SCREEN_WIDTH = dsfe_pkg::DEF_SCREEN_WIDTH
) (
    input  wire logic                 clk,
    input  wire logic                 load,
    input  wire logic [7:0]           x_start,
    input  wire logic [7:0]           x_end,
    input  wire logic [7:0]           row,
    input  wire logic [1:0]           color_op,
    input  wire logic                 dithered,
    input  wire logic [6:0]           window_left,
    input  wire logic [5:0]           window_top,
    input  wire logic [7:0]           window_width,
    input  wire logic [6:0]           window_height,
    input  wire logic [4:0]           dither_level,
    output dsfe_pkg::span_plan_t      plan
);

    localparam int ROW_BYTES = SCREEN_WIDTH / 8;

    dsfe_pkg::span_plan_t plan_reg;
    dsfe_pkg::span_plan_t plan_next;

    logic [7:0] lo;
    logic [7:0] hi;
    logic [7:0] lo_t;
    logic [7:0] hi_t;
    logic [7:0] hi_c;
    logic [7:0] y_t;
    logic [8:0] limit;

    always_comb
    begin
        // order the ends
        if (x_end < x_start)
        begin
            lo = x_end;
            hi = x_start;
        end
        else
        begin
            lo = x_start;
            hi = x_end;
        end

        // translate by the window origin, wrapping at 8 bits
        lo_t  = lo + {1'b0, window_left};
        hi_t  = hi + {1'b0, window_left};
        y_t   = row + {2'b00, window_top};
        limit = {2'b00, window_left} + {1'b0, window_width};

        // clip the right end to the window
        if ({1'b0, hi_t} >= limit)
        begin
            hi_c = 8'(limit - 9'd1);
        end
        else
        begin
            hi_c = hi_t;
        end

        plan_next.drawn      = (lo < window_width) && (row < {1'b0, window_height});
        plan_next.op         = dsfe_pkg::color_op_t'(color_op);
        plan_next.pat        = dithered ? dsfe_pkg::dither_row(dither_level, y_t[1:0])
                                        : 8'hff;
        plan_next.mask_start = 8'hff >> lo_t[2:0];
        plan_next.mask_end   = 8'hff << (3'd7 - hi_c[2:0]);
        plan_next.base       = dsfe_pkg::SPAN_ADDR_W'(y_t)
                             * dsfe_pkg::SPAN_ADDR_W'(ROW_BYTES);
        plan_next.byte_start = lo_t[7:3];
        plan_next.byte_end   = hi_c[7:3];
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            plan_reg <= plan_next;
        end
    end

    assign plan = plan_reg;

endmodule
`default_nettype wire

@@ hdl/dsfe_rmw.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// Span read-modify-write walker
// Walk the span's bytes, one read per cycle, write back in the next cycle.
// ---------------------------------------------------------------------------
module dsfe_rmw #(
    parameter int STORE_SIZE = dsfe_pkg::DEF_SCREEN_WIDTH / 8 * dsfe_pkg::DEF_SCREEN_HEIGHT,
    localparam int AW        = (STORE_SIZE > 1) ? $clog2(STORE_SIZE) : 1
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    input  wire dsfe_pkg::span_plan_t plan,
    output logic                      done,
    output logic                      rd_en,
    output logic [AW-1:0]             rd_addr,
    input  wire logic [7:0]           rd_data,
    output logic                      wr_en,
    output logic [AW-1:0]             wr_addr,
    output logic [7:0]                wr_data
);

    typedef enum logic [4:0] {
        P_IDLE  = 5'b00001,
        P_FIRST = 5'b00010,
        P_LAST  = 5'b00100,
        P_MID   = 5'b01000,
        P_DRAIN = 5'b10000
    } phase_t;

    phase_t     phase_reg;
    phase_t     phase_next;
    logic [5:0] cur_reg;
    logic [5:0] cur_next;

    logic          wr_pend_reg;
    logic          wr_pend_next;
    logic [AW-1:0] wr_addr_reg;
    logic [7:0]    wr_mask_reg;
    logic          wr_whole_reg;

    logic                             issue;
    logic [4:0]                       col;
    logic [7:0]                       mask;
    logic                             whole;
    logic [dsfe_pkg::SPAN_ADDR_W-1:0] addr;
    logic                             in_range;
    logic [5:0]                       cur_inc;

    always_comb
    begin
        phase_next = phase_reg;
        cur_next   = cur_reg;
        issue      = 1'b0;
        col        = plan.byte_start;
        mask       = 8'hff;
        whole      = 1'b0;
        cur_inc    = cur_reg + 6'd1;
        unique case (phase_reg)
            P_IDLE:
            begin
                if (start)
                begin
                    phase_next = P_FIRST;
                end
            end
            P_FIRST:
            begin
                issue = 1'b1;
                col   = plan.byte_start;
                if (plan.byte_start == plan.byte_end)
                begin
                    mask       = plan.mask_start & plan.mask_end & plan.pat;
                    phase_next = P_DRAIN;
                end
                else
                begin
                    mask       = plan.mask_start & plan.pat;
                    phase_next = P_LAST;
                end
            end
            P_LAST:
            begin
                issue    = 1'b1;
                col      = plan.byte_end;
                mask     = plan.mask_end & plan.pat;
                cur_next = {1'b0, plan.byte_start} + 6'd1;
                // end wrapped left of start leaves no interior bytes
                if (cur_next < {1'b0, plan.byte_end})
                begin
                    phase_next = P_MID;
                end
                else
                begin
                    phase_next = P_DRAIN;
                end
            end
            P_MID:
            begin
                issue    = 1'b1;
                col      = cur_reg[4:0];
                whole    = 1'b1;
                cur_next = cur_inc;
                if (cur_inc >= {1'b0, plan.byte_end})
                begin
                    phase_next = P_DRAIN;
                end
            end
            P_DRAIN:
            begin
                phase_next = P_IDLE;
            end
            default:
            begin
                phase_next = P_IDLE;
            end
        endcase

        addr         = plan.base + dsfe_pkg::SPAN_ADDR_W'(col);
        // bytes past the store are dropped
        in_range     = {1'b0, addr} < dsfe_pkg::SIZE_W'(STORE_SIZE);
        wr_pend_next = issue && in_range;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= P_IDLE;
            wr_pend_reg <= 1'b0;
        end
        else
        begin
            phase_reg   <= phase_next;
            wr_pend_reg <= wr_pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg      <= cur_next;
        wr_addr_reg  <= addr[AW-1:0];
        wr_mask_reg  <= mask;
        wr_whole_reg <= whole;
    end

    // modify the byte that came back from the read issued last cycle
    always_comb
    begin
        case (plan.op)
            dsfe_pkg::OP_CLEAR:
                wr_data = wr_whole_reg ? ~plan.pat : (rd_data & ~wr_mask_reg);
            dsfe_pkg::OP_SET:
                wr_data = wr_whole_reg ? plan.pat : (rd_data | wr_mask_reg);
            dsfe_pkg::OP_INVERT:
                wr_data = rd_data ^ (wr_whole_reg ? plan.pat : wr_mask_reg);
            default:
                wr_data = rd_data;
        endcase
    end

    assign rd_en   = wr_pend_next;
    assign rd_addr = addr[AW-1:0];
    assign wr_en   = wr_pend_reg;
    assign wr_addr = wr_addr_reg;
    assign done    = (phase_reg == P_DRAIN);

endmodule
`default_nettype wire

@@ hdl/dithered_span_fill_engine_top.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// Dithered span fill engine
// 1-bit-per-pixel framebuffer with clipped, optionally dithered span fills
// and single-byte reads.
// ---------------------------------------------------------------------------
//
//  channel   dir   handshake          payload
//  s_*       in    s_tvalid/s_tready  s_tdata: fill/read item, s_tuser: func
//  m_*       out   m_tvalid/m_tready  m_tdata: read_data, drawn
//  cfg_*     in    cfg_we             cfg_index, cfg_data (no read-back)
//
//  A fill item passes S_PLAN, S_FILL and S_DONE before the next accept; the
//  walker covers the span's n bytes (up to SCREEN_WIDTH/8 for a window inside
//  the screen, 32 for the widest register values); the single RAM read port
//  walks one byte per cycle and the write back follows in the next cycle.
//  A read item passes S_RDWAIT and S_DONE, a rejected span S_PLAN and S_DONE.
//  After reset the store is cleared one byte per cycle, all SCREEN_WIDTH/8 *
//  SCREEN_HEIGHT bytes (1024 by default), with s_tready low.
//  A result waits in the output register while the next item is accepted;
//  the engine holds a new result until that register frees up.
//
module dithered_span_fill_engine_top #(
    parameter int SCREEN_WIDTH  = dsfe_pkg::DEF_SCREEN_WIDTH,
    parameter int SCREEN_HEIGHT = dsfe_pkg::DEF_SCREEN_HEIGHT
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // input items
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // [7:0] x_start, [15:8] x_end, [23:16] row, [25:24] color_op,
    // [26] dithered, [36:27] read_addr, [39:37] zero
    input  wire logic [39:0] s_tdata,
    // [0] func
    input  wire logic        s_tuser,
    // result items
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // [7:0] read_data, [8] drawn, [15:9] zero
    output logic [15:0]      m_tdata,
    // configuration writes
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [7:0]  cfg_data
);

    localparam int ROW_BYTES  = SCREEN_WIDTH / 8;
    localparam int STORE_SIZE = ROW_BYTES * SCREEN_HEIGHT;
    localparam int AW         = (STORE_SIZE > 1) ? $clog2(STORE_SIZE) : 1;

    typedef enum logic [5:0] {
        S_CLEAR  = 6'b000001,
        S_IDLE   = 6'b000010,
        S_PLAN   = 6'b000100,
        S_FILL   = 6'b001000,
        S_RDWAIT = 6'b010000,
        S_DONE   = 6'b100000
    } state_t;

    // ---- input fields ----
    logic [7:0] x_start;
    logic [7:0] x_end;
    logic [7:0] row;
    logic [1:0] color_op;
    logic       dithered;
    logic [9:0] read_addr;

    assign x_start   = s_tdata[7:0];
    assign x_end     = s_tdata[15:8];
    assign row       = s_tdata[23:16];
    assign color_op  = s_tdata[25:24];
    assign dithered  = s_tdata[26];
    assign read_addr = s_tdata[36:27];

    // ---- configuration registers ----
    logic [6:0] window_left_reg;
    logic [5:0] window_top_reg;
    logic [7:0] window_width_reg;
    logic [6:0] window_height_reg;
    logic [4:0] dither_level_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_left_reg   <= dsfe_pkg::RST_WINDOW_LEFT;
            window_top_reg    <= dsfe_pkg::RST_WINDOW_TOP;
            window_width_reg  <= dsfe_pkg::RST_WINDOW_WIDTH;
            window_height_reg <= dsfe_pkg::RST_WINDOW_HEIGHT;
            dither_level_reg  <= dsfe_pkg::RST_DITHER_LEVEL;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                dsfe_pkg::CFG_WINDOW_LEFT:   window_left_reg   <= cfg_data[6:0];
                dsfe_pkg::CFG_WINDOW_TOP:    window_top_reg    <= cfg_data[5:0];
                dsfe_pkg::CFG_WINDOW_WIDTH:  window_width_reg  <= cfg_data;
                dsfe_pkg::CFG_WINDOW_HEIGHT: window_height_reg <= cfg_data[6:0];
                dsfe_pkg::CFG_DITHER_LEVEL:
                begin
                    // drop levels beyond the table
                    if (cfg_data[4:0] <= dsfe_pkg::MAX_DITHER_LEVEL)
                    begin
                        dither_level_reg <= cfg_data[4:0];
                    end
                end
                default: ;
            endcase
        end
    end

    // ---- control ----
    state_t        state_reg;
    state_t        state_next;
    logic [AW-1:0] clr_cnt_reg;
    logic [AW-1:0] clr_cnt_next;
    logic          rd_ok_reg;
    logic          rd_ok_next;
    logic [7:0]    res_data_reg;
    logic [7:0]    res_data_next;
    logic          res_drawn_reg;
    logic          res_drawn_next;
    logic          out_valid_reg;
    logic          out_valid_next;
    logic [7:0]    out_data_reg;
    logic          out_drawn_reg;

    logic in_accept;
    logic out_load;
    logic rmw_start;
    logic rmw_done;

    dsfe_pkg::span_plan_t plan;

    // RAM ports
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [7:0]    ram_wdata;
    logic          ram_re;
    logic [AW-1:0] ram_raddr;
    logic [7:0]    ram_rdata;

    logic          rmw_rd_en;
    logic [AW-1:0] rmw_rd_addr;
    logic          rmw_wr_en;
    logic [AW-1:0] rmw_wr_addr;
    logic [7:0]    rmw_wr_data;

    logic          item_rd_ok;
    logic [dsfe_pkg::SPAN_ADDR_W-1:0] item_rd_addr;

    assign s_tready     = (state_reg == S_IDLE);
    assign in_accept    = s_tvalid && s_tready;
    assign item_rd_addr = dsfe_pkg::SPAN_ADDR_W'(read_addr);
    assign item_rd_ok   = dsfe_pkg::SIZE_W'(read_addr) < dsfe_pkg::SIZE_W'(STORE_SIZE);

    always_comb
    begin
        state_next     = state_reg;
        clr_cnt_next   = clr_cnt_reg;
        rd_ok_next     = rd_ok_reg;
        res_data_next  = res_data_reg;
        res_drawn_next = res_drawn_reg;
        rmw_start      = 1'b0;
        out_load       = 1'b0;
        unique case (state_reg)
            S_CLEAR:
            begin
                // sweep zeros through the store
                clr_cnt_next = clr_cnt_reg + AW'(1);
                if (clr_cnt_reg == AW'(STORE_SIZE - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_accept)
                begin
                    if (s_tuser == dsfe_pkg::FUNC_READ)
                    begin
                        rd_ok_next = item_rd_ok;
                        state_next = S_RDWAIT;
                    end
                    else
                    begin
                        state_next = S_PLAN;
                    end
                end
            end
            S_PLAN:
            begin
                res_data_next  = 8'h00;
                res_drawn_next = plan.drawn;
                // a rejected span or the no-change op touches no byte
                if (plan.drawn && (plan.op != dsfe_pkg::OP_NONE))
                begin
                    rmw_start  = 1'b1;
                    state_next = S_FILL;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_FILL:
            begin
                if (rmw_done)
                begin
                    state_next = S_DONE;
                end
            end
            S_RDWAIT:
            begin
                res_data_next  = rd_ok_reg ? ram_rdata : 8'h00;
                res_drawn_next = 1'b0;
                state_next     = S_DONE;
            end
            S_DONE:
            begin
                // hold until the output register is free
                if (!out_valid_reg || m_tready)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_ok_reg     <= rd_ok_next;
        res_data_reg  <= res_data_next;
        res_drawn_reg <= res_drawn_next;
        if (out_load)
        begin
            out_data_reg  <= res_data_reg;
            out_drawn_reg <= res_drawn_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'b0000000, out_drawn_reg, out_data_reg};

    // ---- RAM port selection: clear sweep, item read, span walker ----
    always_comb
    begin
        if (state_reg == S_CLEAR)
        begin
            ram_we    = 1'b1;
            ram_waddr = clr_cnt_reg;
            ram_wdata = 8'h00;
        end
        else
        begin
            ram_we    = rmw_wr_en;
            ram_waddr = rmw_wr_addr;
            ram_wdata = rmw_wr_data;
        end

        if (in_accept && (s_tuser == dsfe_pkg::FUNC_READ))
        begin
            ram_re    = item_rd_ok;
            ram_raddr = item_rd_addr[AW-1:0];
        end
        else
        begin
            ram_re    = rmw_rd_en;
            ram_raddr = rmw_rd_addr;
        end
    end

    dsfe_span_plan #(
        .SCREEN_WIDTH (SCREEN_WIDTH)
    ) u_plan (
        .clk           (clk),
        .load          (in_accept && (s_tuser == dsfe_pkg::FUNC_FILL)),
        .x_start       (x_start),
        .x_end         (x_end),
        .row           (row),
        .color_op      (color_op),
        .dithered      (dithered),
        .window_left   (window_left_reg),
        .window_top    (window_top_reg),
        .window_width  (window_width_reg),
        .window_height (window_height_reg),
        .dither_level  (dither_level_reg),
        .plan          (plan)
    );

    dsfe_rmw #(
        .STORE_SIZE (STORE_SIZE)
    ) u_rmw (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (rmw_start),
        .plan    (plan),
        .done    (rmw_done),
        .rd_en   (rmw_rd_en),
        .rd_addr (rmw_rd_addr),
        .rd_data (ram_rdata),
        .wr_en   (rmw_wr_en),
        .wr_addr (rmw_wr_addr),
        .wr_data (rmw_wr_data)
    );

    dsfe_ram #(
        .WIDTH (8),
        .DEPTH (STORE_SIZE)
    ) u_frame_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

endmodule
`default_nettype wire
